// ----- rtl/ultrasonic_echo_ranger_defines.svh -----
// Assertion macros used by the checker of the echo ranger.
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UER_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UER_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/uer_pkg.sv -----
package uer_pkg;

  // Default wrap point of the echo counter.
  localparam int unsigned COUNT_LIMIT_DEF = 10000;

  // Distance per tick is TICK_MM_NUM / MM_DEN millimeters (0.343 mm/us * 10 us / 2).
  localparam int unsigned TICK_MM_NUM = 1715;
  localparam int unsigned MM_DEN      = 1000;
  localparam int unsigned MM_WHOLE    = TICK_MM_NUM / MM_DEN;
  localparam int unsigned MM_FRAC     = TICK_MM_NUM % MM_DEN;
  localparam int unsigned REM_W       = $clog2(MM_DEN);

  localparam int unsigned TIMER_W = 20;
  localparam int unsigned DIST_W  = 16;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_BUSY = 2'd2;

  localparam logic [DIST_W-1:0] DIST_BUSY = 16'hFFFF;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_TRIGGER_TICKS = 3'd0;
  localparam logic [2:0] REG_RISE_TIMEOUT  = 3'd1;
  localparam logic [2:0] REG_FALL_TIMEOUT  = 3'd2;
  localparam logic [2:0] REG_MIN_DISTANCE  = 3'd3;
  localparam logic [2:0] REG_MAX_DISTANCE  = 3'd4;

  // Register reset values.
  localparam logic [7:0]         TRIGGER_TICKS_RST = 8'd2;
  localparam logic [TIMER_W-1:0] RISE_TIMEOUT_RST  = 20'd100000;
  localparam logic [TIMER_W-1:0] FALL_TIMEOUT_RST  = 20'd100000;
  localparam logic [DIST_W-1:0]  MIN_DISTANCE_RST  = 16'd240;
  localparam logic [DIST_W-1:0]  MAX_DISTANCE_RST  = 16'd6000;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TRIG = 4'b0010,
    PH_RISE = 4'b0100,
    PH_HIGH = 4'b1000
  } uer_phase_t;

  typedef struct packed {
    logic [7:0]         trigger_ticks;
    logic [TIMER_W-1:0] rise_timeout;
    logic [TIMER_W-1:0] fall_timeout;
    logic [DIST_W-1:0]  min_distance;
    logic [DIST_W-1:0]  max_distance;
  } uer_cfg_t;

  // One result item; trigger_level sits in the lowest bit.
  typedef struct packed {
    logic [1:0]        status;
    logic [DIST_W-1:0] distance_mm;
    logic              result_valid;
    logic              trigger_level;
  } uer_res_t;

endpackage

// ----- rtl/uer_core.sv -----
module uer_core #(
  parameter int unsigned COUNT_LIMIT = uer_pkg::COUNT_LIMIT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             start_req,
  input  logic             echo_level,
  input  uer_pkg::uer_cfg_t cfg,
  output uer_pkg::uer_res_t res
);

  localparam int unsigned CNT_W = $clog2(COUNT_LIMIT);
  localparam int unsigned TW    = uer_pkg::TIMER_W;
  localparam int unsigned DW    = uer_pkg::DIST_W;
  localparam int unsigned RW    = uer_pkg::REM_W;

  uer_pkg::uer_phase_t phase_r, phase_nxt;
  logic [TW-1:0]    timer_r, timer_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  // Running distance and its remainder in thousandths, kept in step with cnt_r.
  logic [DW-1:0]    dist_r, dist_nxt;
  logic [RW-1:0]    rem_r, rem_nxt;

  logic [TW-1:0]    timer_inc;
  logic [RW:0]      rem_sum;
  logic [CNT_W-1:0] cnt_stp;
  logic [DW-1:0]    dist_stp;
  logic [RW-1:0]    rem_stp;

  // Build a finished result from a distance, applying the range check.
  function automatic uer_pkg::uer_res_t finish_res(logic [DW-1:0] d,
                                                   uer_pkg::uer_cfg_t c);
    uer_pkg::uer_res_t r;
    r = '0;
    r.result_valid = 1'b1;
    if ((d < c.min_distance) || (d > c.max_distance)) begin
      r.status = uer_pkg::ST_BAD;
    end else begin
      r.distance_mm = d;
      r.status      = uer_pkg::ST_OK;
    end
    return r;
  endfunction

  assign timer_inc = timer_r + TW'(1);

  // Count one more high tick: distance grows by the whole part and a carry
  // out of the remainder; the count wraps at the limit and clears both.
  always_comb begin
    rem_sum = {1'b0, rem_r} + (RW + 1)'(uer_pkg::MM_FRAC);
    if (cnt_r >= CNT_W'(COUNT_LIMIT - 1)) begin
      cnt_stp  = '0;
      dist_stp = '0;
      rem_stp  = '0;
    end else if (rem_sum >= (RW + 1)'(uer_pkg::MM_DEN)) begin
      cnt_stp  = cnt_r + CNT_W'(1);
      dist_stp = dist_r + DW'(uer_pkg::MM_WHOLE + 1);
      rem_stp  = RW'(rem_sum - (RW + 1)'(uer_pkg::MM_DEN));
    end else begin
      cnt_stp  = cnt_r + CNT_W'(1);
      dist_stp = dist_r + DW'(uer_pkg::MM_WHOLE);
      rem_stp  = RW'(rem_sum);
    end
  end

  // Per-tick sequencing of trigger, wait for rise and high count.
  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    cnt_nxt   = cnt_r;
    dist_nxt  = dist_r;
    rem_nxt   = rem_r;
    res       = '0;
    case (phase_r)
      uer_pkg::PH_IDLE: begin
        if (start_req) begin
          if (echo_level) begin
            res.result_valid = 1'b1;
            res.distance_mm  = uer_pkg::DIST_BUSY;
            res.status       = uer_pkg::ST_BUSY;
          end else begin
            res.trigger_level = 1'b1;
            phase_nxt         = uer_pkg::PH_TRIG;
            timer_nxt         = TW'(1);
          end
        end
      end
      uer_pkg::PH_TRIG: begin
        if (timer_r >= TW'(cfg.trigger_ticks)) begin
          phase_nxt = uer_pkg::PH_RISE;
          timer_nxt = '0;
        end else begin
          res.trigger_level = 1'b1;
          timer_nxt         = timer_inc;
        end
      end
      uer_pkg::PH_RISE: begin
        if (echo_level) begin
          // First high tick: count one, distance of one tick.
          cnt_nxt   = CNT_W'(1);
          dist_nxt  = DW'(uer_pkg::MM_WHOLE);
          rem_nxt   = RW'(uer_pkg::MM_FRAC);
          phase_nxt = uer_pkg::PH_HIGH;
          timer_nxt = TW'(1);
          if (cfg.fall_timeout <= TW'(1)) begin
            res       = finish_res(DW'(uer_pkg::MM_WHOLE), cfg);
            phase_nxt = uer_pkg::PH_IDLE;
            timer_nxt = '0;
          end
        end else begin
          timer_nxt = timer_inc;
          if (timer_inc >= cfg.rise_timeout) begin
            res.result_valid = 1'b1;
            res.status       = uer_pkg::ST_BAD;
            phase_nxt        = uer_pkg::PH_IDLE;
            timer_nxt        = '0;
          end
        end
      end
      uer_pkg::PH_HIGH: begin
        if (!echo_level) begin
          res       = finish_res(dist_r, cfg);
          phase_nxt = uer_pkg::PH_IDLE;
          timer_nxt = '0;
        end else begin
          cnt_nxt   = cnt_stp;
          dist_nxt  = dist_stp;
          rem_nxt   = rem_stp;
          timer_nxt = timer_inc;
          if (timer_inc >= cfg.fall_timeout) begin
            res       = finish_res(dist_stp, cfg);
            phase_nxt = uer_pkg::PH_IDLE;
            timer_nxt = '0;
          end
        end
      end
      default: begin
        phase_nxt = uer_pkg::PH_IDLE;
        timer_nxt = '0;
      end
    endcase
  end

  // State advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= uer_pkg::PH_IDLE;
      timer_r <= '0;
      cnt_r   <= '0;
      dist_r  <= '0;
      rem_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      cnt_r   <= cnt_nxt;
      dist_r  <= dist_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule

// ----- rtl/ultrasonic_echo_ranger.sv -----
// Ultrasonic echo ranger: each input transfer is one 10 us tick carrying a
// start request and the sampled echo level, and each tick yields exactly one
// output transfer with the trigger level to drive and, when a measurement
// ends, the distance in mm and a status. A tick is accepted every clock
// cycle while input ready is high, and its result is registered; the whole
// tick is handled by one pass through the phase sequencer, with the distance
// kept as a running value so no multiply or divide is needed. A two-entry
// output stage (output register plus skid register) keeps input ready while
// one result waits; input ready drops only when both entries are full.
module ultrasonic_echo_ranger #(
  parameter int unsigned COUNT_LIMIT = uer_pkg::COUNT_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input ticks.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] start_req, [1] echo_level
  // Results.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] trigger_level, [1] result_valid,
                                  // [17:2] distance_mm, [19:18] status
  // Configuration.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  uer_pkg::uer_cfg_t cfg_r;
  uer_pkg::uer_res_t res;
  uer_pkg::uer_res_t out_r, skid_r;
  logic              out_valid_r, skid_valid_r;
  logic              in_fire, out_fire, cfg_wr;
  logic [2:0]        cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_ticks <= uer_pkg::TRIGGER_TICKS_RST;
      cfg_r.rise_timeout  <= uer_pkg::RISE_TIMEOUT_RST;
      cfg_r.fall_timeout  <= uer_pkg::FALL_TIMEOUT_RST;
      cfg_r.min_distance  <= uer_pkg::MIN_DISTANCE_RST;
      cfg_r.max_distance  <= uer_pkg::MAX_DISTANCE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        uer_pkg::REG_TRIGGER_TICKS: cfg_r.trigger_ticks <= cfg_pwdata[7:0];
        uer_pkg::REG_RISE_TIMEOUT:  cfg_r.rise_timeout  <= cfg_pwdata[19:0];
        uer_pkg::REG_FALL_TIMEOUT:  cfg_r.fall_timeout  <= cfg_pwdata[19:0];
        uer_pkg::REG_MIN_DISTANCE:  cfg_r.min_distance  <= cfg_pwdata[15:0];
        uer_pkg::REG_MAX_DISTANCE:  cfg_r.max_distance  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (cfg_idx)
      uer_pkg::REG_TRIGGER_TICKS: cfg_prdata = 32'(cfg_r.trigger_ticks);
      uer_pkg::REG_RISE_TIMEOUT:  cfg_prdata = 32'(cfg_r.rise_timeout);
      uer_pkg::REG_FALL_TIMEOUT:  cfg_prdata = 32'(cfg_r.fall_timeout);
      uer_pkg::REG_MIN_DISTANCE:  cfg_prdata = 32'(cfg_r.min_distance);
      uer_pkg::REG_MAX_DISTANCE:  cfg_prdata = 32'(cfg_r.max_distance);
      default:                    cfg_prdata = '0;
    endcase
  end

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;

  uer_core #(
    .COUNT_LIMIT(COUNT_LIMIT)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_fire),
    .start_req  (in_tdata[0]),
    .echo_level (in_tdata[1]),
    .cfg        (cfg_r),
    .res        (res)
  );

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_tready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_tready) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_r};

endmodule

// ----- rtl/uer_checker.sv -----
`include "ultrasonic_echo_ranger_defines.svh"

module uer_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  logic        res_trig;
  logic        res_fin;
  logic [15:0] res_dist;
  logic [1:0]  res_stat;
  logic [21:0] res_upper;
  logic        stall;
  logic        busy;
  logic        busy_ok;

  // Result fields as they sit in the output transfer.
  assign res_trig  = out_tdata[0];
  assign res_fin   = out_tdata[1];
  assign res_dist  = out_tdata[17:2];
  assign res_stat  = out_tdata[19:18];
  assign res_upper = out_tdata[23:2];
  assign stall     = out_tvalid && !out_tready;
  assign busy      = out_tvalid && (res_stat == uer_pkg::ST_BUSY);
  assign busy_ok   = res_fin && (res_dist == uer_pkg::DIST_BUSY);

  // A stalled result transfer keeps its contents.
  `UER_ASSERT_NEXT(a_out_hold, clk, rst_n, stall, out_tvalid && $stable(out_tdata), "stalled result changed")

  // A tick without a finished measurement carries no distance and no status.
  `UER_ASSERT_NOW(a_idle_zero, clk, rst_n, out_tvalid && !res_fin, res_upper == '0, "data without a result")

  // Echo busy always reports the full-scale distance.
  `UER_ASSERT_NOW(a_busy_code, clk, rst_n, busy, busy_ok, "busy status without busy distance")

  // The trigger is never driven on a tick that ends a measurement.
  `UER_ASSERT_NOW(a_trig_excl, clk, rst_n, out_tvalid && res_trig, !res_fin, "trigger high on a finishing tick")

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
